FILE: rtl/ibc_pkg.sv
// Shared types and constants for the interleaved bitplane to chunky converter.
// No dependencies.
package ibc_pkg;

	localparam int WORD_W       = 16;
	localparam int INDEX_W      = 8;
	localparam int GROUP_PIXELS = 16;
	localparam int PIX_CNT_W    = 4;
	localparam int SHIFT_W      = 2;
	localparam int ROW_GROUPS_W = 9;
	localparam int PLANE_POW_W  = 4;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_SHIFT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_GROUPS  = 1'd1;

	localparam logic [SHIFT_W-1:0]      PLANE_SHIFT_RST = 2'd2;
	localparam logic [ROW_GROUPS_W-1:0] ROW_GROUPS_RST  = 9'd20;

	// one group of chunky pixels, element 0 is the leftmost pixel
	typedef logic [GROUP_PIXELS-1:0][INDEX_W-1:0] group_pixels_t;

endpackage

FILE: rtl/ibc_group_out.sv
// Output stage: holds one group of 16 chunky pixels and emits one per transaction.
// Depends on ibc_pkg.
module ibc_group_out import ibc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  group_pixels_t       pixels,
	input  logic                row_last,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [INDEX_W-1:0]  pixel_index,
	output logic                group_last,
	output logic                row_end
);

	group_pixels_t         grp_q;
	logic [PIX_CNT_W-1:0]  cnt_q;
	logic                  valid_q;
	logic                  row_last_q;
	logic                  take;
	logic                  done;

	// handshake and end of group
	assign take = valid_q & out_ready;
	assign done = take && (cnt_q == PIX_CNT_W'(GROUP_PIXELS - 1));
	assign free = !valid_q || done;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			if (done) begin
				valid_q <= 1'b0;
			end
			cnt_q <= cnt_q + PIX_CNT_W'(1);
		end
	end

	// pixel shift register, pixel to emit sits in element 0
	always_ff @(posedge clk) begin
		if (load) begin
			grp_q      <= pixels;
			row_last_q <= row_last;
		end else if (take) begin
			grp_q <= {{INDEX_W{1'b0}}, grp_q[GROUP_PIXELS-1:1]};
		end
	end

	assign out_valid   = valid_q;
	assign pixel_index = grp_q[0];
	assign group_last  = (cnt_q == PIX_CNT_W'(GROUP_PIXELS - 1));
	assign row_end     = group_last & row_last_q;

endmodule

FILE: rtl/interleaved_bitplane_to_chunky_unit.sv
// Interleaved bitplane to chunky converter, top level; depends on ibc_pkg and ibc_group_out.
// Output: the first pixel of a group is valid in the cycle after the group's last plane word is taken.
// Rate: one pixel per cycle while out_ready is held high; plane words of the next group
//   are taken while a group drains, and only the completing word waits for the output stage.
// Reset: asynchronous, clears counters and output valid, loads register defaults.
module interleaved_bitplane_to_chunky_unit import ibc_pkg::*; #(
	parameter int MAX_PLANES     = 8,
	parameter int MAX_ROW_GROUPS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [WORD_W-1:0]       plane_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [INDEX_W-1:0]      pixel_index,
	output logic                    group_last,
	output logic                    row_end
);

	localparam int PC_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int N_W   = $clog2(MAX_PLANES + 1);
	localparam int BUF_D = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
	localparam int BI_W  = (BUF_D > 1) ? $clog2(BUF_D) : 1;
	localparam int GC_W  = (MAX_ROW_GROUPS > 1) ? $clog2(MAX_ROW_GROUPS) : 1;
	localparam int RG_BASE_W = ($clog2(MAX_ROW_GROUPS + 1) > ROW_GROUPS_W) ?
		$clog2(MAX_ROW_GROUPS + 1) : ROW_GROUPS_W;
	localparam int RG_W  = RG_BASE_W + 1;

	logic [SHIFT_W-1:0]      plane_shift_q;
	logic [ROW_GROUPS_W-1:0] row_groups_q;
	logic [PC_W-1:0]         plane_cnt_q;
	logic [GC_W-1:0]         group_cnt_q;
	logic [WORD_W-1:0]       plane_buf_q [BUF_D];

	logic [PLANE_POW_W-1:0]  plane_pow;
	logic [N_W-1:0]          planes;
	logic [N_W:0]            cnt_next_w;
	logic                    grp_done;
	logic [RG_W-1:0]         rg_act;
	logic [RG_W-1:0]         grp_next_w;
	logic                    row_last;
	logic                    in_accept;
	logic                    load;
	logic                    out_free;
	logic [WORD_W-1:0]       words [MAX_PLANES];
	group_pixels_t           pixels;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_shift_q <= PLANE_SHIFT_RST;
			row_groups_q  <= ROW_GROUPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_SHIFT: plane_shift_q <= cfg_data[SHIFT_W-1:0];
				REG_ROW_GROUPS:  row_groups_q  <= cfg_data[ROW_GROUPS_W-1:0];
				default: ;
			endcase
		end
	end

	// active plane count, limited to the build maximum
	assign plane_pow = PLANE_POW_W'(1) << plane_shift_q;
	assign planes    = (plane_pow > PLANE_POW_W'(MAX_PLANES)) ? N_W'(MAX_PLANES)
		: N_W'(plane_pow);

	// a word completes the group once the counter plus one reaches the plane count
	assign cnt_next_w = (N_W + 1)'(plane_cnt_q) + (N_W + 1)'(1);
	assign grp_done   = !(cnt_next_w < (N_W + 1)'(planes));

	// active row length, zero or oversize means the maximum
	assign rg_act = (row_groups_q == '0 ||
		RG_W'(row_groups_q) > RG_W'(MAX_ROW_GROUPS)) ? RG_W'(MAX_ROW_GROUPS)
		: RG_W'(row_groups_q);
	assign grp_next_w = RG_W'(group_cnt_q) + RG_W'(1);
	assign row_last   = !(grp_next_w < rg_act);

	// the completing word waits only for the output stage
	assign in_ready  = !grp_done || out_free;
	assign in_accept = in_valid & in_ready;
	assign load      = in_accept & grp_done;

	// plane and group counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_cnt_q <= '0;
			group_cnt_q <= '0;
		end else if (in_accept) begin
			if (grp_done) begin
				plane_cnt_q <= '0;
				if (row_last) begin
					group_cnt_q <= '0;
				end else begin
					group_cnt_q <= GC_W'(grp_next_w);
				end
			end else begin
				plane_cnt_q <= PC_W'(cnt_next_w);
			end
		end
	end

	// held plane words of the current group
	always_ff @(posedge clk) begin
		if (in_accept && !grp_done) begin
			plane_buf_q[plane_cnt_q[BI_W-1:0]] <= plane_word;
		end
	end

	// plane words of the group, the arriving word is the last plane
	always_comb begin
		for (int p = 0; p < MAX_PLANES; p++) begin
			words[p] = '0;
		end
		for (int p = 0; p < MAX_PLANES - 1; p++) begin
			words[p] = plane_buf_q[BI_W'(p)];
		end
		for (int p = 0; p < MAX_PLANES; p++) begin
			if (N_W'(p) == planes - N_W'(1)) begin
				words[p] = plane_word;
			end
		end
	end

	// bitplane to chunky transpose, leftmost pixel from bit 15
	always_comb begin
		for (int i = 0; i < GROUP_PIXELS; i++) begin
			pixels[i] = '0;
			for (int p = 0; p < MAX_PLANES; p++) begin
				if (N_W'(p) < planes) begin
					pixels[i][p] = words[p][WORD_W - 1 - i];
				end
			end
		end
	end

	ibc_group_out u_group_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.pixels      (pixels),
		.row_last    (row_last),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.group_last  (group_last),
		.row_end     (row_end)
	);

	// a completed group shows up at the output in the next cycle
	a_load_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("completed group not presented at output");

	// input stalls only behind a group still draining
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output stage");

	// the last group of a row restarts the group count
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(load && row_last) |=> (group_cnt_q == '0))
		else $error("group counter did not wrap at row end");

endmodule

FILE: bench/chunky_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the interleaved bitplane to chunky converter: mirrors register writes,
// predicts the chunky pixels of every finished group and compares them in order.
// Depends on ibc_pkg.
module chunky_pixel_checker import ibc_pkg::*; #(
	parameter int MAX_PLANES     = 8,
	parameter int MAX_ROW_GROUPS = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [WORD_W-1:0]      plane_word,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [INDEX_W-1:0]     pixel_index,
	input  logic                   group_last,
	input  logic                   row_end,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               group_end;
		logic               row_last;
	} pixel_t;

	// predicted pixels, oldest first
	pixel_t expected_pixels[$];

	// mirrored registers and conversion state
	logic [SHIFT_W-1:0]      plane_shift;
	logic [ROW_GROUPS_W-1:0] row_groups;
	logic [WORD_W-1:0]       held_words [MAX_PLANES];
	int unsigned             words_held;
	int unsigned             groups_done;

	int fail_count = 0;
	int queued     = 0;

	assign mismatches = fail_count;
	assign pending    = queued;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// take one plane word; the last word of a group yields its sixteen pixels
	task automatic absorb_plane_word(input logic [WORD_W-1:0] word);
		int unsigned       planes;
		int unsigned       row_len;
		int                p;
		int                i;
		logic              row_last;
		logic [WORD_W-1:0] group_words [MAX_PLANES];
		pixel_t            px;

		planes = 1 << plane_shift;
		if (planes > MAX_PLANES)
			planes = MAX_PLANES;

		// still filling the group
		if (words_held + 1 < planes) begin
			held_words[words_held] = word;
			words_held = (words_held + 1) % 8;
			return;
		end

		// a counter already past a shrunk plane count completes the group too
		for (p = 0; p < MAX_PLANES; p++)
			group_words[p] = (p + 1 < planes) ? held_words[p] : '0;
		group_words[planes - 1] = word;
		words_held = 0;

		row_len = (row_groups == 0 || row_groups > MAX_ROW_GROUPS) ? MAX_ROW_GROUPS
			: row_groups;
		if (groups_done + 1 >= row_len) begin
			row_last = 1'b1;
			groups_done = 0;
		end else begin
			row_last = 1'b0;
			groups_done++;
		end

		// leftmost pixel first, bit p of the index from plane p
		for (i = 0; i < GROUP_PIXELS; i++) begin
			px.index = '0;
			for (p = 0; p < planes; p++)
				px.index[p] = group_words[p][GROUP_PIXELS - 1 - i];
			px.group_end = (i == GROUP_PIXELS - 1);
			px.row_last  = (i == GROUP_PIXELS - 1) && row_last;
			expected_pixels.push_back(px);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			plane_shift = PLANE_SHIFT_RST;
			row_groups  = ROW_GROUPS_RST;
			foreach (held_words[k])
				held_words[k] = '0;
			words_held  = 0;
			groups_done = 0;
			queued      = 0;
		end else begin
			// each pixel transaction against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("pixel with none expected, index", 16'(pixel_index), '0);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_index !== want.index)
						report_mismatch("pixel_index", 16'(pixel_index), 16'(want.index));
					if (group_last !== want.group_end)
						report_mismatch("group_last", 16'(group_last), 16'(want.group_end));
					if (row_end !== want.row_last)
						report_mismatch("row_end", 16'(row_end), 16'(want.row_last));
				end
			end

			// plane word transaction
			if (in_valid && in_ready)
				absorb_plane_word(plane_word);

			// register writes leave the counters alone
			if (cfg_we) begin
				case (cfg_index)
					REG_PLANE_SHIFT: plane_shift = cfg_data[SHIFT_W-1:0];
					REG_ROW_GROUPS:  row_groups  = cfg_data[ROW_GROUPS_W-1:0];
					default: ;
				endcase
			end

			queued = expected_pixels.size();
		end
	end

endmodule

FILE: bench/interleaved_bitplane_to_chunky_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the interleaved bitplane to chunky converter: clock, reset,
// register and plane word stimulus, output backpressure and the verdict.
// Depends on ibc_pkg, interleaved_bitplane_to_chunky_unit and chunky_pixel_checker.
module interleaved_bitplane_to_chunky_unit_tb;
	import ibc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TOTAL_WORDS   = 280;

	localparam logic [WORD_W-1:0] EXTREME_WORDS [8] = '{
		16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
		16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [WORD_W-1:0]      plane_word;
	logic                   out_valid;
	logic                   out_ready;
	logic [INDEX_W-1:0]     pixel_index;
	logic                   group_last;
	logic                   row_end;

	int          mismatches;
	int          pending;
	int unsigned cycle_count = 0;
	int          words_sent  = 0;
	bit          tx_burst    = 1'b0;
	bit          rx_no_stall = 1'b0;

	interleaved_bitplane_to_chunky_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plane_word  (plane_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.group_last  (group_last),
		.row_end     (row_end)
	);

	chunky_pixel_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plane_word  (plane_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.group_last  (group_last),
		.row_end     (row_end),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// all tasks start and end on a falling edge

	// one plane word transaction after a random gap, or with no gap in burst mode
	task automatic send_word(input logic [WORD_W-1:0] word);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid   <= 1'b0;
			plane_word <= WORD_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		plane_word <= word;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_sent++;
	endtask

	// hold the sender until every predicted pixel has come out
	task automatic wait_results_done(input int settle);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (settle) @(negedge clk);
	endtask

	// write both registers on back-to-back cycles
	task automatic set_config(input int shift, input int rows);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PLANE_SHIFT;
		cfg_data  <= CFG_DATA_W'(shift);
		@(negedge clk);
		cfg_index <= REG_ROW_GROUPS;
		cfg_data  <= CFG_DATA_W'(rows);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	// pixel receiver: random stall before each pixel, or none at all
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = rx_no_stall ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		int shift;
		int rows;
		int planes;
		int groups;
		int extra;
		int phase;

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_PLANE_SHIFT;
		cfg_data   = '0;
		in_valid   = 1'b0;
		plane_word = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: four planes, twenty groups per row
		send_word(16'hFFFF);
		send_word(16'h0000);
		send_word(16'hF0F0);
		send_word(16'h0F0F);
		wait_results_done(SETTLE_CYCLES);

		// eight planes, one group per row, extreme plane words
		set_config(3, 1);
		foreach (EXTREME_WORDS[i])
			send_word(EXTREME_WORDS[i]);
		wait_results_done(SETTLE_CYCLES);

		// plane count shrunk mid-group: five words held, then two planes
		for (int i = 0; i < 5; i++)
			send_word(random_word());
		wait_results_done(SETTLE_CYCLES);
		set_config(1, 1);
		send_word(random_word());
		wait_results_done(SETTLE_CYCLES);

		// zero row length reads as the longest row, then the row shrinks mid-row
		set_config(0, 0);
		send_word(16'h8001);
		send_word(16'h7FFE);
		send_word(random_word());
		wait_results_done(SETTLE_CYCLES);
		set_config(0, 2);
		send_word(16'hC003);

		// random phases, each with its own setting and pacing
		phase = 0;
		while (words_sent < TOTAL_WORDS) begin
			wait_results_done(SETTLE_CYCLES);
			case (phase)
				0: begin shift = 0; rows = 0;   end
				1: begin shift = 3; rows = 256; end
				2: begin shift = 0; rows = 511; end
				3: begin shift = 2; rows = 300; end
				4: begin shift = 1; rows = 1;   end
				default: begin
					shift = $urandom_range(0, 3);
					rows  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
						: $urandom_range(1, 5);
				end
			endcase
			set_config(shift, rows);
			tx_burst    = ($urandom_range(0, 3) == 0);
			rx_no_stall = ($urandom_range(0, 3) == 0);
			planes = 1 << shift;
			groups = (phase == 0) ? 24 : $urandom_range(1, 24 / planes + 1);
			// sometimes leave a partial group over the next register write
			extra  = (planes > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, planes - 1) : 0;

			for (int w = 0; w < groups * planes + extra; w++) begin
				if ($urandom_range(0, 19) == 0)
					wait_results_done(0);
				send_word(random_word());
			end
			phase++;
		end

		wait_results_done(20);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
